FILE: rtl/core/tlm_pkg.sv
// Shared types and constants for the token list membership block.
`timescale 1ns / 1ps

package tlm_pkg;

   localparam int MAX_WORD_DEF   = 8;
   localparam int MAX_DELIMS_DEF = 4;

   localparam int CHAR_W      = 8;
   localparam int WORD_BYTES  = 8;
   localparam int SWORD_W     = 64;
   localparam int SLEN_W      = 4;
   localparam int DSET_W      = 32;
   localparam int DCNT_W      = 3;
   localparam int CSR_DATA_W  = 64;
   localparam int CSR_INDEX_W = 3;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_SEARCH_WORD     = 3'd0,
      REG_SEARCH_LENGTH   = 3'd1,
      REG_DELIMITER_SET   = 3'd2,
      REG_DELIMITER_COUNT = 3'd3,
      REG_IGNORE_CASE     = 3'd4
   } reg_index_type;

   typedef enum logic [1:0] {
      PH_BETWEEN = 2'd0,
      PH_LEAD    = 2'd1,
      PH_WORD    = 2'd2,
      PH_TAIL    = 2'd3
   } phase_type;

   typedef struct packed {
      logic [SWORD_W-1:0] search_word;
      logic [SLEN_W-1:0]  search_length;
      logic [DSET_W-1:0]  delimiter_set;
      logic [DCNT_W-1:0]  delimiter_count;
      logic               ignore_case;
   } cfg_type;

   localparam logic [CHAR_W-1:0] CHAR_NUL = 8'h00;

endpackage

FILE: rtl/core/tlm_csr.sv
// Configuration registers of the token list membership block.
`timescale 1ns / 1ps

module tlm_csr
   import tlm_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_wr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wr_data,
   output cfg_type                cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (reg_index_type'(csr_wr_index))
            REG_SEARCH_WORD:     cfg_in.search_word     = csr_wr_data[SWORD_W-1:0];
            REG_SEARCH_LENGTH:   cfg_in.search_length   = csr_wr_data[SLEN_W-1:0];
            REG_DELIMITER_SET:   cfg_in.delimiter_set   = csr_wr_data[DSET_W-1:0];
            REG_DELIMITER_COUNT: cfg_in.delimiter_count = csr_wr_data[DCNT_W-1:0];
            REG_IGNORE_CASE:     cfg_in.ignore_case     = csr_wr_data[0];
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: rtl/core/tlm_scan.sv
// Per-byte token scanner: classification, word compare and match state.
`timescale 1ns / 1ps

module tlm_scan
   import tlm_pkg::*;
#(
   parameter int MAX_WORD   = MAX_WORD_DEF,
   parameter int MAX_DELIMS = MAX_DELIMS_DEF
)(
   input  logic              clock,
   input  logic              reset,
   input  cfg_type           cfg,
   input  logic              step,
   input  logic [CHAR_W-1:0] char_in,
   output logic              found
);

   localparam int LEN_W = $clog2(MAX_WORD + 2);
   localparam logic [LEN_W-1:0] LEN_MAX  = LEN_W'(MAX_WORD);
   localparam logic [LEN_W-1:0] LEN_OVER = LEN_W'(MAX_WORD + 1);

   function automatic logic [CHAR_W-1:0] fold(input logic ic, input logic [CHAR_W-1:0] c);
      logic [CHAR_W-1:0] r;
      r = c;
      if (ic && c >= 8'h41 && c <= 8'h5A) begin
         r = c + 8'h20;
      end
      return r;
   endfunction

   phase_type        phase_ff, phase_in;
   logic [LEN_W-1:0] length_ff, length_in;
   logic             equal_ff, equal_in;
   logic             any_ff, any_in;

   logic              is_nul;
   logic              is_delim;
   logic              is_space;
   logic              token_hit;
   logic [CHAR_W-1:0] search_byte;
   logic              byte_differs;
   logic              len_ok;

   always_comb begin
      is_delim = 1'b0;
      for (int i = 0; i < MAX_DELIMS; i++) begin
         if (DCNT_W'(i) < cfg.delimiter_count &&
             cfg.delimiter_set[CHAR_W*i +: CHAR_W] == char_in) begin
            is_delim = 1'b1;
         end
      end
   end

   always_comb begin
      search_byte = '0;
      for (int k = 0; k < WORD_BYTES; k++) begin
         if ({{(SLEN_W+1){1'b0}}, length_ff} == (SLEN_W + 1 + LEN_W)'(k)) begin
            search_byte = cfg.search_word[CHAR_W*k +: CHAR_W];
         end
      end
   end

   assign is_nul   = (char_in == CHAR_NUL);
   assign is_space = (char_in == 8'h20) || (char_in >= 8'h09 && char_in <= 8'h0D);
   assign len_ok   = ({1'b0, cfg.search_length} <= (SLEN_W + 1)'(MAX_WORD));
   assign byte_differs = ({{SLEN_W{1'b0}}, length_ff} >= {{LEN_W{1'b0}}, cfg.search_length})
                      || (fold(cfg.ignore_case, search_byte) != fold(cfg.ignore_case, char_in));
   assign token_hit = (phase_ff != PH_BETWEEN) && equal_ff && len_ok &&
                      ({{SLEN_W{1'b0}}, length_ff} == {{LEN_W{1'b0}}, cfg.search_length});
   assign found = any_ff || token_hit;

   always_comb begin
      phase_in  = phase_ff;
      length_in = length_ff;
      equal_in  = equal_ff;
      any_in    = any_ff;
      if (step) begin
         if (is_nul) begin
            phase_in  = PH_BETWEEN;
            length_in = '0;
            equal_in  = 1'b1;
            any_in    = 1'b0;
         end else if (is_delim) begin
            any_in    = found;
            phase_in  = PH_BETWEEN;
            length_in = '0;
            equal_in  = 1'b1;
         end else begin
            case (phase_ff)
               PH_BETWEEN, PH_LEAD, PH_WORD: begin
                  if (is_space) begin
                     phase_in = (phase_ff == PH_WORD) ? PH_TAIL : PH_LEAD;
                  end else begin
                     phase_in = PH_WORD;
                     if (length_ff < LEN_MAX) begin
                        if (byte_differs) begin
                           equal_in = 1'b0;
                        end
                        length_in = length_ff + 1'b1;
                     end else begin
                        length_in = LEN_OVER;
                        equal_in  = 1'b0;
                     end
                  end
               end
               default: begin
                  phase_in = phase_ff;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_BETWEEN;
         length_ff <= '0;
         equal_ff  <= 1'b1;
         any_ff    <= 1'b0;
      end else begin
         phase_ff  <= phase_in;
         length_ff <= length_in;
         equal_ff  <= equal_in;
         any_ff    <= any_in;
      end
   end

endmodule

FILE: rtl/core/token_list_membership_top.sv
// Top level of the token list membership block: item registers and scanner.
//
//   channel | direction | payload
//   req     | in        | tdata[7:0] = char_in
//   rsp     | out       | tdata[0] = found, tdata[7:1] = 0
//   csr     | in        | wr_index selects register, wr_data[63:0]
//
// One item per cycle sustained unless a zero byte waits; an accepted byte is scanned from the input register.
// A zero byte puts one item in the result register on the next edge.
// A zero byte waits in the input register while the result register is full
// and not being taken; other bytes never wait.
// Synchronous reset clears the scan state, the configuration and both valid flags.
`timescale 1ns / 1ps

module token_list_membership_top
   import tlm_pkg::*;
#(
   parameter int MAX_WORD   = MAX_WORD_DEF,
   parameter int MAX_DELIMS = MAX_DELIMS_DEF
)(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [7:0]             req_tdata,   // [7:0] char_in
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [7:0]             rsp_tdata,   // [0] found, [7:1] zero
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_wr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wr_data
);

   cfg_type cfg;

   logic              in_valid_ff, in_valid_in;
   logic [CHAR_W-1:0] in_char_ff, in_char_in;
   logic              out_valid_ff, out_valid_in;
   logic              out_found_ff, out_found_in;

   logic step;
   logic is_nul;
   logic found;

   tlm_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_index (csr_wr_index),
      .csr_wr_data  (csr_wr_data),
      .cfg          (cfg)
   );

   tlm_scan #(
      .MAX_WORD   (MAX_WORD),
      .MAX_DELIMS (MAX_DELIMS)
   ) u_scan (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .step    (step),
      .char_in (in_char_ff),
      .found   (found)
   );

   assign is_nul     = (in_char_ff == CHAR_NUL);
   assign step       = in_valid_ff && (!is_nul || !out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || step;

   always_comb begin
      in_valid_in  = in_valid_ff;
      in_char_in   = in_char_ff;
      out_valid_in = out_valid_ff;
      out_found_in = out_found_ff;
      if (req_tready) begin
         in_valid_in = req_tvalid;
         in_char_in  = req_tdata;
      end
      if (out_valid_ff && rsp_tready) begin
         out_valid_in = 1'b0;
      end
      if (step && is_nul) begin
         out_valid_in = 1'b1;
         out_found_in = found;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
      in_char_ff   <= in_char_in;
      out_found_ff <= out_found_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {7'd0, out_found_ff};

endmodule

FILE: rtl/core/tlm_checker.sv
// Port-level checks for the token list membership block, bound to the top level.
`timescale 1ns / 1ps

module tlm_checker
   import tlm_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_tvalid,
   input logic       req_tready,
   input logic [7:0] req_tdata,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result item changed while stalled");

   a_rsp_pad: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[7:1] == 7'd0)
      else $error("result padding bits not zero");

   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready && req_tdata == CHAR_NUL, 2))
      else $error("result item without a terminating byte");

   a_req_flow: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled while result register empty");

endmodule

bind token_list_membership_top tlm_checker u_tlm_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
